// ===== rtl/fcr_pkg.sv =====
// Shared constants and answer-frame byte generator for the framed command receiver.
package fcr_pkg;

  localparam int unsigned BUF_BYTES_DEF = 1024;
  localparam int unsigned KW            = 10;   // frame offset counter, frames are <= 519 bytes

  localparam logic [7:0]  START_BYTE  = 8'hAA;
  localparam logic [7:0]  ESC_BYTE    = 8'h1B;
  localparam logic [7:0]  ESC_FLIP    = 8'h20;
  localparam logic [7:0]  TYPE_ACK    = 8'h7E;
  localparam logic [7:0]  TYPE_NACK   = 8'h7F;
  localparam logic [7:0]  TYPE_HB     = 8'h00;
  localparam logic [7:0]  TYPE_MOTOR  = 8'h01;
  localparam logic [7:0]  TYPE_SERVO  = 8'h02;
  localparam logic [7:0]  TYPE_CONFIG = 8'h10;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] MAX_LEN     = 16'd512;
  localparam logic [8:0]  PAYLOAD_CAP = 9'd256;

  localparam logic [1:0] ST_ACK     = 2'd0;
  localparam logic [1:0] ST_CRC_ERR = 2'd1;
  localparam logic [1:0] ST_LEN_ERR = 2'd2;
  localparam logic [1:0] ST_UNK     = 2'd3;

  localparam logic [2:0] KIND_HB     = 3'd0;
  localparam logic [2:0] KIND_MOTOR  = 3'd1;
  localparam logic [2:0] KIND_SERVO  = 3'd2;
  localparam logic [2:0] KIND_CONFIG = 3'd3;
  localparam logic [2:0] KIND_NONE   = 3'd4;

  localparam logic [2:0] LED_NONE    = 3'd0;
  localparam logic [2:0] LED_MAGENTA = 3'd1;
  localparam logic [2:0] LED_YELLOW  = 3'd2;
  localparam logic [2:0] LED_BLUE    = 3'd3;
  localparam logic [2:0] LED_CYAN    = 3'd4;
  localparam logic [2:0] LED_RED     = 3'd5;

  // stuffed payload length of the answer: {seq} or {seq, err}, seq maybe escaped
  function automatic logic [3:0] ans_plen(input logic nack, input logic [7:0] seq);
    logic pst;
    pst = (seq == START_BYTE) || (seq == ESC_BYTE);
    return 4'd1 + {3'd0, pst} + {3'd0, nack};
  endfunction

  function automatic logic [7:0] ans_byte(input logic [3:0] i, input logic nack,
                                          input logic [7:0] seq, input logic [1:0] err,
                                          input logic [15:0] crc);
    logic       pst;
    logic [3:0] pl;
    logic [3:0] p;
    logic [7:0] b;
    pst = (seq == START_BYTE) || (seq == ESC_BYTE);
    pl  = ans_plen(nack, seq);
    p   = i - 4'd5;
    if (i == 4'd0) begin
      b = START_BYTE;
    end else if (i == 4'd1) begin
      b = nack ? TYPE_NACK : TYPE_ACK;
    end else if (i == 4'd2) begin
      b = seq;
    end else if (i == 4'd3) begin
      b = {4'd0, pl};
    end else if (i == 4'd4) begin
      b = 8'd0;
    end else if (i == 4'd5 + pl) begin
      b = crc[7:0];
    end else if (i == 4'd6 + pl) begin
      b = crc[15:8];
    end else if (pst) begin
      if (p == 4'd0) b = ESC_BYTE;
      else if (p == 4'd1) b = seq ^ ESC_FLIP;
      else b = {6'd0, err};
    end else begin
      if (p == 4'd0) b = seq;
      else b = {6'd0, err};
    end
    return b;
  endfunction

endpackage

// ===== rtl/fcr_crc16.sv =====
// CRC-16 (poly 0x1021, MSB first) byte update unit, shared by frame check and answer build.
module fcr_crc16
  import fcr_pkg::*;
(
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data_in, 8'd0};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    crc_out = c;
  end

endmodule

// ===== rtl/fcr_rx_mem.sv =====
// Receive byte buffer: one write port, one registered read port.
module fcr_rx_mem
  import fcr_pkg::*;
#(
  parameter int unsigned BUF_BYTES = BUF_BYTES_DEF,
  parameter int unsigned AW        = $clog2(BUF_BYTES)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [BUF_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/framed_command_receiver.sv =====
// Top level: byte-stuffed command frame receiver with CRC check and ACK/NACK answer.
//
// Usage:
//  - in_* carries one received UART byte per request (in_tdata[7:0]).
//  - out_* carries the answer frame (0xAA, 0x7E/0x7F, seq, len, stuffed payload,
//    CRC lo/hi) one byte per request; out_tlast marks its final byte. Every byte
//    of one answer carries the same status, kind and decoded command fields.
//  - Bytes go into a circular buffer. When 7 bytes are held the header is read
//    back; when the whole frame is held it is walked once (1 byte/cycle through
//    the shared CRC unit and the unstuffer), then the answer CRC is built over
//    up to 7 bytes with the same unit, then the answer is sent.
//  - in_tready is high only while idle. A full frame is followed by the answer
//    (up to 10 bytes, one per cycle without stall). The longest busy spell is
//    set by the buffer read walk of a 512-byte frame.
//  - A stalled out_tready simply holds the current answer byte; no input is
//    taken until the last answer byte is accepted.
//  - Reset (rst_n low, synchronous) empties the buffer; no clearing pass.
//  - A byte that does not fit the buffer empties it and starts a new one.
module framed_command_receiver
  import fcr_pkg::*;
#(
  parameter int unsigned BUF_BYTES = BUF_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] rx_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // [7:0] resp_byte, [23:8] motor_left, [39:24] motor_right, [47:40] servo_channel,
  // [63:48] servo_pulse, [71:64] config_key, [103:72] config_value, [106:104] led_color
  output logic [111:0] out_tdata,
  output logic         out_tlast,  // resp_last
  output logic [4:0]   out_tuser   // [1:0] resp_status, [4:2] msg_kind
);

  localparam int unsigned AW = $clog2(BUF_BYTES);
  localparam int unsigned CW = $clog2(BUF_BYTES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_RD, S_DEC_HDR, S_DEC_FRM, S_ANS_CRC, S_EMIT
  } state_t;

  state_t          state_r, state_nxt;
  logic            phase_frm_r, phase_frm_nxt;
  logic [AW-1:0]   head_r, head_nxt, tail_r, tail_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [KW-1:0]   iss_k_r, iss_k_nxt, rd_k_r, rd_k_nxt, end_r, end_nxt;
  logic [KW-1:0]   flen_r, flen_nxt;
  logic            rd_v_r, rd_v_nxt;
  logic [7:0]      b0_r, b0_nxt, type_r, type_nxt, seq_r, seq_nxt;
  logic [15:0]     len_r, len_nxt, crc_r, crc_nxt, got_r, got_nxt;
  logic            esc_r, esc_nxt;
  logic [8:0]      plen_r, plen_nxt;
  logic [7:0]      pl_r [5];
  logic [7:0]      pl_nxt [5];
  logic            nack_r, nack_nxt;
  logic [1:0]      err_r, err_nxt, status_r, status_nxt;
  logic [2:0]      kind_r, kind_nxt, led_r, led_nxt;
  logic [15:0]     left_r, left_nxt, right_r, right_nxt, pulse_r, pulse_nxt;
  logic [7:0]      chan_r, chan_nxt, key_r, key_nxt;
  logic [31:0]     value_r, value_nxt;
  logic [3:0]      idx_r, idx_nxt;

  logic            mem_we;
  logic [7:0]      rd_data;
  logic [7:0]      crc_byte;
  logic [15:0]     crc_upd;
  logic [3:0]      ans_pl;
  logic [7:0]      ans_b;
  logic [KW-1:0]   pay_end;
  logic [7:0]      uv;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(BUF_BYTES - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_tready  = (state_r == S_IDLE);
  assign mem_we     = in_tvalid && in_tready;
  assign ans_pl     = ans_plen(nack_r, seq_r);
  assign ans_b      = ans_byte(idx_r, nack_r, seq_r, err_r, crc_r);
  assign pay_end    = flen_r - KW'(3);
  assign crc_byte   = (state_r == S_ANS_CRC) ? ans_b : rd_data;
  assign uv         = esc_r ? (rd_data ^ ESC_FLIP) : rd_data;

  assign out_tvalid = (state_r == S_EMIT);
  assign out_tlast  = (idx_r == ans_pl + 4'd6);
  assign out_tuser  = {kind_r, status_r};
  assign out_tdata  = {5'd0, led_r, value_r, key_r, pulse_r, chan_r, right_r, left_r, ans_b};

  fcr_rx_mem #(.BUF_BYTES(BUF_BYTES), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (tail_r),
    .wdata (in_tdata),
    .raddr (rd_ptr_r),
    .rdata (rd_data)
  );

  fcr_crc16 u_crc (
    .crc_in  (crc_r),
    .data_in (crc_byte),
    .crc_out (crc_upd)
  );

  always_comb begin
    state_nxt = state_r;   phase_frm_nxt = phase_frm_r;
    head_nxt = head_r;     tail_nxt = tail_r;     rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;   iss_k_nxt = iss_k_r;   rd_k_nxt = rd_k_r;
    end_nxt = end_r;       flen_nxt = flen_r;     rd_v_nxt = 1'b0;
    b0_nxt = b0_r;         type_nxt = type_r;     seq_nxt = seq_r;
    len_nxt = len_r;       crc_nxt = crc_r;       got_nxt = got_r;
    esc_nxt = esc_r;       plen_nxt = plen_r;     pl_nxt = pl_r;
    nack_nxt = nack_r;     err_nxt = err_r;       status_nxt = status_r;
    kind_nxt = kind_r;     led_nxt = led_r;       left_nxt = left_r;
    right_nxt = right_r;   pulse_nxt = pulse_r;   chan_nxt = chan_r;
    key_nxt = key_r;       value_nxt = value_r;   idx_nxt = idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          tail_nxt = ptr_inc(tail_r);
          if (count_r == CW'(BUF_BYTES)) begin
            // no room: drop everything held and start over with this byte
            head_nxt  = tail_r;
            count_nxt = CW'(1);
          end else begin
            count_nxt = count_r + 1'b1;
          end
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        if (count_r == CW'(7)) begin
          phase_frm_nxt = 1'b0;
          end_nxt       = KW'(4);
          rd_ptr_nxt    = head_r;
          iss_k_nxt     = '0;
          state_nxt     = S_RD;
        end else if (16'(count_r) == 16'(flen_r)) begin
          phase_frm_nxt = 1'b1;
          end_nxt       = flen_r - KW'(1);
          rd_ptr_nxt    = head_r;
          iss_k_nxt     = '0;
          crc_nxt       = CRC_INIT;
          esc_nxt       = 1'b0;
          plen_nxt      = '0;
          state_nxt     = S_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_RD: begin
        // issue side: one buffer read per cycle
        if (iss_k_r <= end_r) begin
          rd_v_nxt   = 1'b1;
          rd_k_nxt   = iss_k_r;
          rd_ptr_nxt = ptr_inc(rd_ptr_r);
          iss_k_nxt  = iss_k_r + 1'b1;
        end
        // consume side: data of last cycle's read
        if (rd_v_r) begin
          if (!phase_frm_r) begin
            case (rd_k_r)
              KW'(0):  b0_nxt = rd_data;
              KW'(1):  type_nxt = rd_data;
              KW'(2):  seq_nxt = rd_data;
              KW'(3):  len_nxt[7:0] = rd_data;
              KW'(4):  len_nxt[15:8] = rd_data;
              default: ;
            endcase
          end else begin
            if (rd_k_r >= KW'(1) && rd_k_r <= pay_end) begin
              crc_nxt = crc_upd;
            end
            if (rd_k_r >= KW'(5) && rd_k_r <= pay_end) begin
              if (!esc_r && rd_data == ESC_BYTE) begin
                esc_nxt = 1'b1;
              end else begin
                esc_nxt = 1'b0;
                if (plen_r < PAYLOAD_CAP) begin
                  if (plen_r < 9'd5) pl_nxt[plen_r[2:0]] = uv;
                  plen_nxt = plen_r + 1'b1;
                end
              end
            end
            if (rd_k_r == flen_r - KW'(2)) got_nxt[7:0]  = rd_data;
            if (rd_k_r == flen_r - KW'(1)) got_nxt[15:8] = rd_data;
          end
          if (rd_k_r == end_r) begin
            state_nxt = phase_frm_r ? S_DEC_FRM : S_DEC_HDR;
          end
        end
      end

      S_DEC_HDR: begin
        if (b0_r != START_BYTE || len_r > MAX_LEN) begin
          head_nxt  = ptr_inc(head_r);
          count_nxt = count_r - 1'b1;
          if (b0_r == START_BYTE) begin
            nack_nxt = 1'b1;  err_nxt = ST_LEN_ERR;  status_nxt = ST_LEN_ERR;
            kind_nxt = KIND_NONE;  led_nxt = LED_NONE;
            left_nxt = '0; right_nxt = '0; chan_nxt = '0; pulse_nxt = '0;
            key_nxt = '0;  value_nxt = '0;
            crc_nxt  = CRC_INIT;
            idx_nxt  = 4'd1;
            state_nxt = S_ANS_CRC;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          flen_nxt = KW'(len_r) + KW'(7);
          if (len_r == 16'd0) begin
            // empty payload: the frame is already complete
            phase_frm_nxt = 1'b1;
            end_nxt       = KW'(6);
            rd_ptr_nxt    = head_r;
            iss_k_nxt     = '0;
            crc_nxt       = CRC_INIT;
            esc_nxt       = 1'b0;
            plen_nxt      = '0;
            state_nxt     = S_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_DEC_FRM: begin
        head_nxt  = tail_r;
        count_nxt = '0;
        left_nxt = '0; right_nxt = '0; chan_nxt = '0; pulse_nxt = '0;
        key_nxt = '0;  value_nxt = '0;
        nack_nxt = 1'b0;  err_nxt = ST_ACK;  status_nxt = ST_ACK;
        if (crc_r != got_r) begin
          nack_nxt = 1'b1;  err_nxt = ST_CRC_ERR;  status_nxt = ST_CRC_ERR;
          kind_nxt = KIND_NONE;  led_nxt = LED_NONE;
        end else begin
          case (type_r)
            TYPE_HB: begin
              kind_nxt = KIND_HB;  led_nxt = LED_MAGENTA;
            end
            TYPE_MOTOR: begin
              kind_nxt = KIND_MOTOR;  led_nxt = LED_YELLOW;
              if (plen_r == 9'd4) begin
                left_nxt  = {pl_r[1], pl_r[0]};
                right_nxt = {pl_r[3], pl_r[2]};
              end else begin
                nack_nxt = 1'b1;  err_nxt = ST_LEN_ERR;  status_nxt = ST_LEN_ERR;
              end
            end
            TYPE_SERVO: begin
              kind_nxt = KIND_SERVO;  led_nxt = LED_BLUE;
              if (plen_r == 9'd3) begin
                chan_nxt  = pl_r[0];
                pulse_nxt = {pl_r[2], pl_r[1]};
              end else begin
                nack_nxt = 1'b1;  err_nxt = ST_LEN_ERR;  status_nxt = ST_LEN_ERR;
              end
            end
            TYPE_CONFIG: begin
              kind_nxt = KIND_CONFIG;  led_nxt = LED_CYAN;
              if (plen_r == 9'd5) begin
                key_nxt   = pl_r[0];
                value_nxt = {pl_r[4], pl_r[3], pl_r[2], pl_r[1]};
              end else begin
                nack_nxt = 1'b1;  err_nxt = ST_LEN_ERR;  status_nxt = ST_LEN_ERR;
              end
            end
            default: begin
              kind_nxt = KIND_NONE;  led_nxt = LED_RED;
              nack_nxt = 1'b1;  err_nxt = ST_UNK;  status_nxt = ST_UNK;
            end
          endcase
        end
        crc_nxt   = CRC_INIT;
        idx_nxt   = 4'd1;
        state_nxt = S_ANS_CRC;
      end

      S_ANS_CRC: begin
        crc_nxt = crc_upd;
        if (idx_r == ans_pl + 4'd4) begin
          idx_nxt   = '0;
          state_nxt = S_EMIT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_EMIT: begin
        if (out_tready) begin
          if (out_tlast) state_nxt = S_IDLE;
          else idx_nxt = idx_r + 1'b1;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      rd_v_r  <= 1'b0;
      flen_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      rd_v_r  <= rd_v_nxt;
      flen_r  <= flen_nxt;
    end
    phase_frm_r <= phase_frm_nxt;
    rd_ptr_r <= rd_ptr_nxt;  iss_k_r <= iss_k_nxt;  rd_k_r <= rd_k_nxt;
    end_r <= end_nxt;        b0_r <= b0_nxt;        type_r <= type_nxt;
    seq_r <= seq_nxt;        len_r <= len_nxt;      crc_r <= crc_nxt;
    got_r <= got_nxt;        esc_r <= esc_nxt;      plen_r <= plen_nxt;
    pl_r <= pl_nxt;          nack_r <= nack_nxt;    err_r <= err_nxt;
    status_r <= status_nxt;  kind_r <= kind_nxt;    led_r <= led_nxt;
    left_r <= left_nxt;      right_r <= right_nxt;  pulse_r <= pulse_nxt;
    chan_r <= chan_nxt;      key_r <= key_nxt;      value_r <= value_nxt;
    idx_r <= idx_nxt;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(BUF_BYTES))
    else $error("buffer count above capacity");

  a_walk_needs_header: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (count_r >= CW'(7)))
    else $error("buffer walk with fewer than a header's bytes");

  a_accept_checks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_CHECK))
    else $error("accepted byte not checked");

  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("input not ready after final answer byte");
`endif

endmodule
